@@ hw/rtl/txsel_pkg.sv @@
// Shared constants, widths and register codes for the text selection hit test.
package txsel_pkg;

    localparam int MAX_ROWS = 4096;
    localparam int MAX_COLS = 256;

    localparam int ROW_W      = 12;
    localparam int COL_W      = 8;
    localparam int CPP_W      = 9;
    localparam int RCNT_W     = 13;
    localparam int FLAG_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // widths of the saturated page sizes
    localparam int RC_W = $clog2(MAX_ROWS + 1);
    localparam int CP_W = $clog2(MAX_COLS + 1);

    // working widths for row and column arithmetic
    localparam int RW = (RC_W > ROW_W + 1) ? RC_W : ROW_W + 1;
    localparam int CW = (CP_W > COL_W + 1) ? CP_W : COL_W + 1;

    localparam logic [CPP_W-1:0]  COLS_RESET = CPP_W'(80);
    localparam logic [RCNT_W-1:0] ROWS_RESET = RCNT_W'(24);

    localparam int FLAG_START_LEFT = 0;
    localparam int FLAG_END_LEFT   = 1;
    localparam int FLAG_BLOCK      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ROW     = 3'd0,
        CFG_START_COL     = 3'd1,
        CFG_END_ROW       = 3'd2,
        CFG_END_COL       = 3'd3,
        CFG_MARK_FLAGS    = 3'd4,
        CFG_COLS_PER_PAGE = 3'd5,
        CFG_ROW_COUNT     = 3'd6
    } cfg_reg_t;

endpackage

@@ hw/rtl/text_selection_hit_test_top.sv @@
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one cell per cycle; the whole test is one compare stage that feeds
// the result register, and input ready drops only while that register is stalled.
// Reset: selection registers return to their defaults (80 columns, 24 rows,
// marks and flags zero) and the result register is emptied.
module text_selection_hit_test_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [txsel_pkg::ROW_W-1:0]         cell_row,
    input  logic [txsel_pkg::COL_W-1:0]         cell_col,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                selected,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [txsel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [txsel_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int RW = txsel_pkg::RW;
    localparam int CW = txsel_pkg::CW;

    logic [txsel_pkg::ROW_W-1:0]  start_row_reg;
    logic [txsel_pkg::COL_W-1:0]  start_col_reg;
    logic [txsel_pkg::ROW_W-1:0]  end_row_reg;
    logic [txsel_pkg::COL_W-1:0]  end_col_reg;
    logic [txsel_pkg::FLAG_W-1:0] mark_flags_reg;
    logic [txsel_pkg::CPP_W-1:0]  cols_per_page_reg;
    logic [txsel_pkg::RCNT_W-1:0] row_count_reg;

    logic out_valid_reg;
    logic selected_reg;
    logic selected_next;

    logic in_fire;
    logic cfg_fire;

    logic blk;
    logic sel_empty;
    logic [txsel_pkg::CP_W-1:0] cpp_c;
    logic [txsel_pkg::RC_W-1:0] rc_c;
    logic [CW-1:0] cpp_w;
    logic [RW-1:0] rc_w;

    logic [txsel_pkg::ROW_W-1:0] a_r, b_r;
    logic [txsel_pkg::COL_W-1:0] a_c, b_c, x_c, y_c;
    logic a_l, b_l, x_l, y_l;
    logic [RW-1:0] r1, r2, row_w;
    logic [CW-1:0] c1, c2, col_w;
    logic start_ok, end_ok;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign selected  = selected_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg     <= '0;
            start_col_reg     <= '0;
            end_row_reg       <= '0;
            end_col_reg       <= '0;
            mark_flags_reg    <= '0;
            cols_per_page_reg <= txsel_pkg::COLS_RESET;
            row_count_reg     <= txsel_pkg::ROWS_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                txsel_pkg::CFG_START_ROW:
                    start_row_reg <= cfg_data[txsel_pkg::ROW_W-1:0];
                txsel_pkg::CFG_START_COL:
                    start_col_reg <= cfg_data[txsel_pkg::COL_W-1:0];
                txsel_pkg::CFG_END_ROW:
                    end_row_reg <= cfg_data[txsel_pkg::ROW_W-1:0];
                txsel_pkg::CFG_END_COL:
                    end_col_reg <= cfg_data[txsel_pkg::COL_W-1:0];
                txsel_pkg::CFG_MARK_FLAGS:
                    mark_flags_reg <= cfg_data[txsel_pkg::FLAG_W-1:0];
                txsel_pkg::CFG_COLS_PER_PAGE:
                    cols_per_page_reg <= cfg_data[txsel_pkg::CPP_W-1:0];
                txsel_pkg::CFG_ROW_COUNT:
                    row_count_reg <= cfg_data[txsel_pkg::RCNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // saturate page sizes into their legal ranges
    always_comb
    begin
        if (cols_per_page_reg == '0)
            cpp_c = txsel_pkg::CP_W'(1);
        else if (32'(cols_per_page_reg) > 32'(txsel_pkg::MAX_COLS))
            cpp_c = txsel_pkg::CP_W'(txsel_pkg::MAX_COLS);
        else
            cpp_c = txsel_pkg::CP_W'(cols_per_page_reg);

        if (row_count_reg == '0)
            rc_c = txsel_pkg::RC_W'(1);
        else if (32'(row_count_reg) > 32'(txsel_pkg::MAX_ROWS))
            rc_c = txsel_pkg::RC_W'(txsel_pkg::MAX_ROWS);
        else
            rc_c = txsel_pkg::RC_W'(row_count_reg);
    end

    assign cpp_w = CW'(cpp_c);
    assign rc_w  = RW'(rc_c);
    assign blk   = mark_flags_reg[txsel_pkg::FLAG_BLOCK];

    // block mode ignores rows when deciding the selection is empty
    assign sel_empty = (start_col_reg == end_col_reg)
                    && (mark_flags_reg[txsel_pkg::FLAG_START_LEFT]
                        == mark_flags_reg[txsel_pkg::FLAG_END_LEFT])
                    && (blk || (start_row_reg == end_row_reg));

    always_comb
    begin
        // order the marks by row
        if (start_row_reg > end_row_reg)
        begin
            a_r = end_row_reg;
            a_c = end_col_reg;
            a_l = mark_flags_reg[txsel_pkg::FLAG_END_LEFT];
            b_r = start_row_reg;
            b_c = start_col_reg;
            b_l = mark_flags_reg[txsel_pkg::FLAG_START_LEFT];
        end
        else
        begin
            a_r = start_row_reg;
            a_c = start_col_reg;
            a_l = mark_flags_reg[txsel_pkg::FLAG_START_LEFT];
            b_r = end_row_reg;
            b_c = end_col_reg;
            b_l = mark_flags_reg[txsel_pkg::FLAG_END_LEFT];
        end

        // order columns in block mode or on a single row; rows stay put
        x_c = a_c;
        y_c = b_c;
        x_l = a_l;
        y_l = b_l;
        if ((a_r == b_r || blk) && a_c >= b_c)
        begin
            if (a_c > b_c)
            begin
                x_c = b_c;
                y_c = a_c;
                x_l = b_l;
                y_l = a_l;
            end
            else if (!a_l && b_l)
            begin
                x_l = 1'b1;
                y_l = 1'b0;
            end
        end

        // right-half start moves forward one cell, wrapping to the next row
        start_ok = 1'b1;
        r1 = RW'(a_r);
        c1 = CW'(x_c);
        if (!x_l)
        begin
            if (CW'(x_c) < cpp_w - CW'(1))
                c1 = CW'(x_c) + CW'(1);
            else if (RW'(a_r) < rc_w - RW'(1))
            begin
                r1 = RW'(a_r) + RW'(1);
                c1 = '0;
            end
            else
                start_ok = 1'b0;
        end

        // left-half end moves back one cell, wrapping to the previous row
        end_ok = 1'b1;
        r2 = RW'(b_r);
        c2 = CW'(y_c);
        if (y_l)
        begin
            if (y_c != '0)
                c2 = CW'(y_c) - CW'(1);
            else if (b_r != '0)
            begin
                r2 = RW'(b_r) - RW'(1);
                c2 = cpp_w - CW'(1);
            end
            else
                end_ok = 1'b0;
        end
    end

    assign row_w = RW'(cell_row);
    assign col_w = CW'(cell_col);

    always_comb
    begin
        if (sel_empty || !start_ok || !end_ok || row_w < r1 || row_w > r2)
            selected_next = 1'b0;
        else if (blk || r1 == r2)
            selected_next = (col_w >= c1) && (col_w <= c2);
        else if (row_w == r1)
            selected_next = (col_w >= c1);
        else if (row_w == r2)
            selected_next = (col_w <= c2);
        else
            selected_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            selected_reg <= selected_next;
    end

    // every accepted beat yields a result beat on the next cycle
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("accepted beat produced no result");

    // input stalls only behind a held result
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready))
        else $error("input stalled without a held result");

    // an empty selection never reports a hit
    a_empty_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && sel_empty) |=> !selected)
        else $error("hit reported for empty selection");

    // a cell outside the row span is never selected
    a_row_span: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (row_w < r1 || row_w > r2)) |=> !selected)
        else $error("hit reported outside selected rows");

endmodule

@@ tb/sv/txsel_tb_pkg.sv @@
// Scoreboard class for the text selection hit test bench: selection copy, predictor, checks.
package txsel_tb_pkg;
    import txsel_pkg::*;

    class txsel_scoreboard;
        logic [ROW_W-1:0]  start_row;
        logic [COL_W-1:0]  start_col;
        logic [ROW_W-1:0]  end_row;
        logic [COL_W-1:0]  end_col;
        logic [FLAG_W-1:0] mark_flags;
        logic [CPP_W-1:0]  cols_per_page;
        logic [RCNT_W-1:0] row_count;

        bit exp_selected_q[$];
        int errors;
        int checked;
        int hits;

        function new();
            reset_regs();
            errors = 0;
            checked = 0;
            hits = 0;
        endfunction

        function void reset_regs();
            start_row     = '0;
            start_col     = '0;
            end_row       = '0;
            end_col       = '0;
            mark_flags    = '0;
            cols_per_page = COLS_RESET;
            row_count     = ROWS_RESET;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_START_ROW:     start_row     = data[ROW_W-1:0];
                CFG_START_COL:     start_col     = data[COL_W-1:0];
                CFG_END_ROW:       end_row       = data[ROW_W-1:0];
                CFG_END_COL:       end_col       = data[COL_W-1:0];
                CFG_MARK_FLAGS:    mark_flags    = data[FLAG_W-1:0];
                CFG_COLS_PER_PAGE: cols_per_page = data[CPP_W-1:0];
                CFG_ROW_COUNT:     row_count     = data[RCNT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit cell_in_selection(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
            int  sr, sc, er, ec, cpp, rc, r1, c1, r2, c2, t, crow, ccol;
            bit  sl, el, blk, tflag;
            sr  = start_row;
            sc  = start_col;
            er  = end_row;
            ec  = end_col;
            sl  = mark_flags[FLAG_START_LEFT];
            el  = mark_flags[FLAG_END_LEFT];
            blk = mark_flags[FLAG_BLOCK];
            crow = row;
            ccol = col;
            cpp = (cols_per_page == 0) ? 1 : (cols_per_page > MAX_COLS) ? MAX_COLS : cols_per_page;
            rc  = (row_count == 0) ? 1 : (row_count > MAX_ROWS) ? MAX_ROWS : row_count;

            // empty selection: block mode ignores rows
            if (blk) begin
                if (sc == ec && sl == el) return 1'b0;
            end
            else if (sr == er && sc == ec && sl == el) begin
                return 1'b0;
            end

            if (sr > er) begin
                t = sr; sr = er; er = t;
                t = sc; sc = ec; ec = t;
                tflag = sl; sl = el; el = tflag;
            end
            if ((sr == er || blk) && sc >= ec) begin
                if (sc > ec) begin
                    t = sc; sc = ec; ec = t;
                    tflag = sl; sl = el; el = tflag;
                end
                else if (!sl && el) begin
                    sl = 1'b1;
                    el = 1'b0;
                end
            end

            // right-half start moves forward, wrapping onto the next row
            if (sl) begin
                r1 = sr; c1 = sc;
            end
            else if (sc < cpp - 1) begin
                r1 = sr; c1 = sc + 1;
            end
            else if (sr < rc - 1) begin
                r1 = sr + 1; c1 = 0;
            end
            else begin
                return 1'b0;
            end

            // left-half end moves back, wrapping onto the previous row
            if (!el) begin
                r2 = er; c2 = ec;
            end
            else if (ec > 0) begin
                r2 = er; c2 = ec - 1;
            end
            else if (er > 0) begin
                r2 = er - 1; c2 = cpp - 1;
            end
            else begin
                return 1'b0;
            end

            if (crow < r1 || crow > r2) return 1'b0;
            if (blk || r1 == r2) return (ccol >= c1 && ccol <= c2);
            if (crow == r1) return (ccol >= c1);
            if (crow == r2) return (ccol <= c2);
            return 1'b1;
        endfunction

        function void note_cell(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
            exp_selected_q.push_back(cell_in_selection(row, col));
        endfunction

        function void check_result(logic sel);
            bit exp_sel;
            if (exp_selected_q.size() == 0) begin
                $error("result beat with no cell waiting: selected expected none, actual %0b",
                       sel);
                errors++;
                return;
            end
            exp_sel = exp_selected_q.pop_front();
            checked++;
            if (exp_sel) hits++;
            if (sel !== exp_sel) begin
                $error("selected mismatch: expected %0b, actual %0b", exp_sel, sel);
                errors++;
            end
        endfunction

        function int pending();
            return exp_selected_q.size();
        endfunction
    endclass

endpackage

@@ tb/sv/tb.sv @@
// Top-level bench for text_selection_hit_test_top: drivers, result monitor and test sequence.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import txsel_pkg::*;
    import txsel_tb_pkg::*;

    localparam int RANDOM_CELLS   = 1550;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ROW_W-1:0]      cell_row = '0;
    logic [COL_W-1:0]      cell_col = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  selected;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    txsel_scoreboard sb = new();

    bit burst_in = 1'b0;
    bit burst_out = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int cells_sent = 0;
    int setups = 0;

    // current marks and effective page size, used to aim cells at the edges
    int sel_sr, sel_sc, sel_er, sel_ec, sel_cpp;

    text_selection_hit_test_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .selected  (selected),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // receiver: random stalls, some stretches always ready
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (burst_out || $urandom_range(0, 99) < 60) begin
            out_ready <= 1'b1;
        end
        else begin
            stall_left <= pick_gap();
            out_ready  <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(selected);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(cfg_reg_t idx, int value, bit junk);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] data;
        case (idx)
            CFG_START_ROW, CFG_END_ROW: mask = CFG_DATA_W'((1 << ROW_W) - 1);
            CFG_START_COL, CFG_END_COL: mask = CFG_DATA_W'((1 << COL_W) - 1);
            CFG_MARK_FLAGS:             mask = CFG_DATA_W'((1 << FLAG_W) - 1);
            CFG_COLS_PER_PAGE:          mask = CFG_DATA_W'((1 << CPP_W) - 1);
            default:                    mask = '1;
        endcase
        data = CFG_DATA_W'(value) & mask;
        // bits above the register width must be dropped by the block
        if (junk) data = data | (CFG_DATA_W'($urandom()) & ~mask);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // let every cell in flight come back before touching the registers
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_selection(int sr, int sc, int er, int ec, int flags, int cpp, int rc,
                                 bit junk);
        drain();
        write_reg(CFG_START_ROW, sr, junk);
        write_reg(CFG_START_COL, sc, junk);
        write_reg(CFG_END_ROW, er, junk);
        write_reg(CFG_END_COL, ec, junk);
        write_reg(CFG_MARK_FLAGS, flags, junk);
        write_reg(CFG_COLS_PER_PAGE, cpp, junk);
        write_reg(CFG_ROW_COUNT, rc, junk);
        cfg_valid <= 1'b0;
        sel_sr  = sr & 12'hFFF;
        sel_sc  = sc & 8'hFF;
        sel_er  = er & 12'hFFF;
        sel_ec  = ec & 8'hFF;
        sel_cpp = ((cpp & 9'h1FF) == 0) ? 1 : ((cpp & 9'h1FF) > MAX_COLS) ? MAX_COLS : (cpp & 9'h1FF);
        burst_in  <= ($urandom_range(0, 4) == 0);
        burst_out <= ($urandom_range(0, 4) == 0);
        setups++;
    endtask

    task automatic send_cell(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        int gap;
        gap = burst_in ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cell_row <= row;
        cell_col <= col;
        do @(posedge clk); while (!in_ready);
        sb.note_cell(row, col);
        cells_sent++;
    endtask

    function automatic logic [ROW_W-1:0] aim_row();
        int lo, hi;
        lo = (sel_sr < sel_er) ? sel_sr : sel_er;
        hi = (sel_sr < sel_er) ? sel_er : sel_sr;
        case ($urandom_range(0, 9))
            0: return ROW_W'(sel_sr);
            1: return ROW_W'(sel_er);
            2: return ROW_W'(sel_sr - 1);
            3: return ROW_W'(sel_sr + 1);
            4: return ROW_W'(sel_er - 1);
            5: return ROW_W'(sel_er + 1);
            6, 7: return ROW_W'($urandom_range(hi, lo));
            default: return ROW_W'($urandom());
        endcase
    endfunction

    function automatic logic [COL_W-1:0] aim_col();
        case ($urandom_range(0, 11))
            0: return COL_W'(sel_sc);
            1: return COL_W'(sel_ec);
            2: return COL_W'(sel_sc + 1);
            3: return COL_W'(sel_sc - 1);
            4: return COL_W'(sel_ec + 1);
            5: return COL_W'(sel_ec - 1);
            6: return COL_W'(0);
            7: return COL_W'(sel_cpp - 1);
            8: return COL_W'(sel_cpp);
            default: return COL_W'($urandom());
        endcase
    endfunction

    function automatic int pick_mark_row(int rc_eff);
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return $urandom_range(0, 15);
        if (r < 40) return rc_eff - 2 + $urandom_range(0, 2);
        if (r < 50) return ($urandom_range(0, 1) == 0) ? 0 : 4095;
        return $urandom_range(0, 4095);
    endfunction

    function automatic int pick_mark_col(int cpp_eff);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return cpp_eff - 1;
                2: return cpp_eff;
                default: return 255;
            endcase
        end
        if (r < 60) return $urandom_range(0, cpp_eff - 1);
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_page_cols();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            case ($urandom_range(0, 6))
                0: return 0;
                1: return 1;
                2: return 2;
                3: return 255;
                4: return 256;
                5: return 257;
                default: return 511;
            endcase
        end
        if (r < 50) return 80;
        if (r < 60) return $urandom_range(0, 511);
        return $urandom_range(1, 256);
    endfunction

    function automatic int pick_page_rows();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            case ($urandom_range(0, 6))
                0: return 0;
                1: return 1;
                2: return 2;
                3: return 4095;
                4: return 4096;
                5: return 4097;
                default: return 8191;
            endcase
        end
        if (r < 45) return 24;
        if (r < 55) return $urandom_range(0, 8191);
        return $urandom_range(1, 4096);
    endfunction

    initial begin
        int rand_cells, n, cpp, rc, cpp_eff, rc_eff, sr, sc, er, ec, shape;
        rand_cells = 0;
        sel_sr = 0; sel_sc = 0; sel_er = 0; sel_ec = 0; sel_cpp = 80;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset selection: both marks equal, so nothing is selected
        send_cell(12'd0, 8'd0);
        send_cell(12'd4095, 8'd255);

        // stream, marks given end first, both on the right half
        set_selection(3, 10, 1, 70, 0, 80, 24, 1'b0);
        send_cell(12'd1, 8'd70);
        send_cell(12'd1, 8'd71);
        send_cell(12'd2, 8'd0);
        send_cell(12'd3, 8'd10);
        send_cell(12'd3, 8'd11);
        send_cell(12'd0, 8'd255);

        // right-half start on the last cell of the last row
        set_selection(23, 79, 30, 5, 0, 80, 24, 1'b0);
        send_cell(12'd23, 8'd79);
        send_cell(12'd30, 8'd5);
        send_cell(12'd25, 8'd0);
        // same marks, more rows held: start wraps onto the next row
        set_selection(23, 79, 30, 5, 0, 80, 8191, 1'b1);
        send_cell(12'd24, 8'd0);
        send_cell(12'd23, 8'd79);

        // left-half end on column 0 wraps back to the previous row
        set_selection(0, 40, 5, 0, 3, 80, 24, 1'b0);
        send_cell(12'd4, 8'd79);
        send_cell(12'd5, 8'd0);
        send_cell(12'd0, 8'd40);

        // block mode, equal columns with opposite halves
        set_selection(10, 20, 2, 20, 6, 80, 24, 1'b0);
        send_cell(12'd5, 8'd20);
        send_cell(12'd5, 8'd21);
        send_cell(12'd11, 8'd20);

        // page sizes saturating low, marks at the far corners
        set_selection(4095, 255, 0, 0, 1, 0, 0, 1'b1);
        send_cell(12'd4095, 8'd255);
        send_cell(12'd0, 8'd0);
        send_cell(12'd2048, 8'd128);

        while (rand_cells < RANDOM_CELLS) begin
            cpp = pick_page_cols();
            rc  = pick_page_rows();
            cpp_eff = (cpp == 0) ? 1 : (cpp > MAX_COLS) ? MAX_COLS : cpp;
            rc_eff  = (rc == 0) ? 1 : (rc > MAX_ROWS) ? MAX_ROWS : rc;
            sr = pick_mark_row(rc_eff);
            sc = pick_mark_col(cpp_eff);
            shape = $urandom_range(0, 99);
            if (shape < 12) begin
                er = sr; ec = sc;
            end
            else if (shape < 30) begin
                er = sr; ec = pick_mark_col(cpp_eff);
            end
            else if (shape < 40) begin
                er = pick_mark_row(rc_eff); ec = sc;
            end
            else if (shape < 70) begin
                er = sr + $urandom_range(0, 6) - 3;
                ec = pick_mark_col(cpp_eff);
            end
            else begin
                er = pick_mark_row(rc_eff); ec = pick_mark_col(cpp_eff);
            end
            set_selection(sr, sc, er, ec, $urandom_range(0, 7), cpp, rc,
                          $urandom_range(0, 3) == 0);
            n = $urandom_range(20, 40);
            repeat (n) begin
                // mostly aimed at the selection's edges, the rest anywhere
                if ($urandom_range(0, 9) < 8)
                    send_cell(aim_row(), aim_col());
                else
                    send_cell(ROW_W'($urandom()), COL_W'($urandom()));
                rand_cells++;
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Tested %0d cells under %0d selection setups, %0d of them inside the selection.",
                 sb.checked, setups, sb.hits);
        $display("Stream and block modes, half-cell wraps, empty marks and saturated page sizes.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end
        else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
